// ===== design/tcpq_pkg.sv =====
// Package for the two-class sorted priority queue.
// Holds the beat types, the queue control struct, field widths and codes.
// No dependencies.
package tcpq_pkg;

  localparam int unsigned DATE_W     = 16;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned ARRIVAL_W  = 17;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned APPT_KEY_W = DATE_W + SLOT_W + ARRIVAL_W;
  localparam int unsigned WALK_KEY_W = DATE_W + ARRIVAL_W;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic SEL_APPT   = 1'b0;
  localparam logic SEL_WALKIN = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                 mode;
    logic                 has_appointment;
    logic                 queue_select;
    logic [DATE_W-1:0]    visit_date;
    logic [SLOT_W-1:0]    slot_number;
    logic [ARRIVAL_W-1:0] arrival_second;
    logic [ID_W-1:0]      person_id;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     removed_id;
    logic [COUNT_W-1:0]  appointment_count;
    logic [COUNT_W-1:0]  walkin_count;
  } out_beat_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } tcpq_ctl_t;

endpackage

// ===== design/tcpq_cell.sv =====
// One cell of a sorted shift-register queue: holds one key and identifier.
// Depends on tcpq_pkg.
module tcpq_cell import tcpq_pkg::*; #(
  parameter int unsigned KEY_W = 33
) (
  input  logic             clk_i,
  input  tcpq_ctl_t        ctl_i,
  input  logic             valid_i,
  input  logic             left_valid_i,
  input  logic             left_gt_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic [ID_W-1:0]  left_id_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic [ID_W-1:0]  right_id_i,
  input  logic [KEY_W-1:0] new_key_i,
  input  logic [ID_W-1:0]  new_id_i,
  output logic             gt_o,
  output logic [KEY_W-1:0] key_o,
  output logic [ID_W-1:0]  id_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [ID_W-1:0]  id_q, id_d;

  assign gt_o = valid_i && (key_q > new_key_i);

  always_comb begin
    key_d = key_q;
    id_d  = id_q;
    if (ctl_i.pop) begin
      key_d = right_key_i;
      id_d  = right_id_i;
    end else if (ctl_i.ins) begin
      if (left_gt_i) begin
        key_d = left_key_i;
        id_d  = left_id_i;
      end else if ((gt_o || !valid_i) && left_valid_i) begin
        key_d = new_key_i;
        id_d  = new_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

  assign key_o = key_q;
  assign id_o  = id_q;

endmodule

// ===== design/tcpq_queue.sv =====
// One sorted queue: a row of tcpq_cell instances and the fill counter.
// Depends on tcpq_pkg and tcpq_cell.
module tcpq_queue import tcpq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned KEY_W = 33,
  localparam int unsigned FILL_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcpq_ctl_t         ctl_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [ID_W-1:0]   id_i,
  output logic              full_o,
  output logic              empty_o,
  output logic [ID_W-1:0]   head_id_o,
  output logic [FILL_W-1:0] fill_o,
  output logic [FILL_W-1:0] fill_nxt_o
);

  logic [FILL_W-1:0] fill_q, fill_d;
  tcpq_ctl_t         cell_ctl;

  logic [KEY_W-1:0] key_w   [DEPTH];
  logic [ID_W-1:0]  id_w    [DEPTH];
  logic             gt_w    [DEPTH];
  logic             valid_w [DEPTH];

  assign full_o  = (fill_q == FILL_W'(DEPTH));
  assign empty_o = (fill_q == '0);

  assign cell_ctl.ins = ctl_i.ins && !full_o;
  assign cell_ctl.pop = ctl_i.pop && !empty_o;

  always_comb begin
    fill_d = fill_q;
    if (cell_ctl.ins) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (cell_ctl.pop) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             left_valid;
    logic             left_gt;
    logic [KEY_W-1:0] left_key;
    logic [ID_W-1:0]  left_id;
    logic [KEY_W-1:0] right_key;
    logic [ID_W-1:0]  right_id;

    assign valid_w[i] = (FILL_W'(i) < fill_q);

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
      assign left_key   = key_i;
      assign left_id    = id_i;
    end else begin : g_body
      assign left_valid = valid_w[i-1];
      assign left_gt    = gt_w[i-1];
      assign left_key   = key_w[i-1];
      assign left_id    = id_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_key = key_w[i];
      assign right_id  = id_w[i];
    end else begin : g_next
      assign right_key = key_w[i+1];
      assign right_id  = id_w[i+1];
    end

    tcpq_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .valid_i     (valid_w[i]),
      .left_valid_i(left_valid),
      .left_gt_i   (left_gt),
      .left_key_i  (left_key),
      .left_id_i   (left_id),
      .right_key_i (right_key),
      .right_id_i  (right_id),
      .new_key_i   (key_i),
      .new_id_i    (id_i),
      .gt_o        (gt_w[i]),
      .key_o       (key_w[i]),
      .id_o        (id_w[i])
    );
  end

  assign head_id_o  = id_w[0];
  assign fill_o     = fill_q;
  assign fill_nxt_o = fill_d;

endmodule

// ===== design/two_class_sorted_priority_queue_top.sv =====
// Two-class sorted priority queue: appointment queue and walk-in queue.
// Top level: input handshake, queue control, registered result beat.
// Depends on tcpq_pkg and tcpq_queue.
//
// Each queue is a row of QUEUE_DEPTH cells that all compare the new key in the
// same cycle and shift one place left or right, so a new beat is accepted
// each cycle while in_ready_o is high. The result beat is registered and
// appears the cycle after its input beat is accepted; in_ready_o drops only
// while a result beat waits on out_ready_i. Entries with equal keys leave in
// arrival order. Counts report the fill modulo 32. No clearing pass after
// reset: the queues start empty.
module two_class_sorted_priority_queue_top import tcpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic      out_valid_q;
  out_beat_t out_data_q, out_data_d;
  logic      accept;
  logic      is_ins, is_pop;

  tcpq_ctl_t              appt_ctl, walk_ctl;
  logic [APPT_KEY_W-1:0]  appt_key;
  logic [WALK_KEY_W-1:0]  walk_key;
  logic                   appt_full, appt_empty, walk_full, walk_empty;
  logic [ID_W-1:0]        appt_head, walk_head;
  logic [FILL_W-1:0]      appt_fill, appt_fill_nxt, walk_fill, walk_fill_nxt;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_ins     = accept && (in_data_i.mode == MODE_INSERT);
  assign is_pop     = accept && (in_data_i.mode == MODE_REMOVE);

  assign appt_key = {in_data_i.visit_date, in_data_i.slot_number, in_data_i.arrival_second};
  assign walk_key = {in_data_i.visit_date, in_data_i.arrival_second};

  assign appt_ctl.ins = is_ins && in_data_i.has_appointment;
  assign appt_ctl.pop = is_pop && (in_data_i.queue_select == SEL_APPT);
  assign walk_ctl.ins = is_ins && !in_data_i.has_appointment;
  assign walk_ctl.pop = is_pop && (in_data_i.queue_select == SEL_WALKIN);

  tcpq_queue #(
    .DEPTH(QUEUE_DEPTH),
    .KEY_W(APPT_KEY_W)
  ) u_appt_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (appt_ctl),
    .key_i     (appt_key),
    .id_i      (in_data_i.person_id),
    .full_o    (appt_full),
    .empty_o   (appt_empty),
    .head_id_o (appt_head),
    .fill_o    (appt_fill),
    .fill_nxt_o(appt_fill_nxt)
  );

  tcpq_queue #(
    .DEPTH(QUEUE_DEPTH),
    .KEY_W(WALK_KEY_W)
  ) u_walk_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (walk_ctl),
    .key_i     (walk_key),
    .id_i      (in_data_i.person_id),
    .full_o    (walk_full),
    .empty_o   (walk_empty),
    .head_id_o (walk_head),
    .fill_o    (walk_fill),
    .fill_nxt_o(walk_fill_nxt)
  );

  always_comb begin
    out_data_d.status            = ST_DONE;
    out_data_d.removed_id        = '0;
    out_data_d.appointment_count = COUNT_W'(appt_fill_nxt);
    out_data_d.walkin_count      = COUNT_W'(walk_fill_nxt);
    if ((appt_ctl.ins && appt_full) || (walk_ctl.ins && walk_full)) begin
      out_data_d.status = ST_FULL;
    end else if ((appt_ctl.pop && appt_empty) || (walk_ctl.pop && walk_empty)) begin
      out_data_d.status = ST_EMPTY;
    end else if (appt_ctl.pop) begin
      out_data_d.removed_id = appt_head;
    end else if (walk_ctl.pop) begin
      out_data_d.removed_id = walk_head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result beat");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (appt_fill <= QUEUE_DEPTH) && (walk_fill <= QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_idle_holds_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(appt_fill) && $stable(walk_fill))
    else $error("queue fill moved without an accepted beat");

  a_reject_holds_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (out_data_d.status != ST_DONE)) |=> $stable(appt_fill) && $stable(walk_fill))
    else $error("queue fill moved on a full insert or empty remove");

endmodule
